>>> design/rbs_pkg.sv
// Shared types and constants for the ray/box slab intersection block.
// No dependencies; every other design file but rbs_checker refers to it by scoped names.
package rbs_pkg;

  // Fraction bits of the fixed-point coordinates
  localparam int FRAC_BITS = 16;
  // Slab distances saturate at 2^TLIM_BITS - 1
  localparam int TLIM_BITS = 62;
  localparam int AXES = 3;
  localparam int REG_IDX_W = 3;

  // Register indexes, one word apart on the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } reg_idx_e;

  // Per-axis flags that travel beside the quotients
  typedef struct packed {
    logic dzero;     // direction component is zero
    logic neg_near;  // near distance is negative
    logic neg_far;   // far distance is negative
  } axis_flags_t;

  // Sideband of one ray through the divider pipeline
  typedef struct packed {
    axis_flags_t [AXES-1:0] ax;
    logic                   miss;  // zero direction with origin outside its slab
  } side_t;

endpackage

>>> design/rbs_cfg_regs.sv
// Box corner registers behind an APB-style port, with read-back.
// Depends on rbs_pkg for the register indexes.
module rbs_cfg_regs #(
  parameter int COORD_WIDTH = 32,
  parameter int ADDR_W = 5,
  parameter int DATA_W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic [COORD_WIDTH-1:0] box_lo [rbs_pkg::AXES],
  output logic [COORD_WIDTH-1:0] box_hi [rbs_pkg::AXES]
);

  rbs_pkg::reg_idx_e idx;
  logic              wr_en;
  logic [COORD_WIDTH-1:0] wval;

  assign idx   = rbs_pkg::reg_idx_e'(paddr[ADDR_W-1:ADDR_W-rbs_pkg::REG_IDX_W]);
  assign wr_en = psel && penable && pwrite;
  assign wval  = pwdata[COORD_WIDTH-1:0];

  // Write the addressed corner; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < rbs_pkg::AXES; a++) begin
        box_lo[a] <= '0;
        box_hi[a] <= '0;
      end
    end else if (wr_en) begin
      unique case (idx)
        rbs_pkg::REG_BOX_MIN_X: box_lo[0] <= wval;
        rbs_pkg::REG_BOX_MIN_Y: box_lo[1] <= wval;
        rbs_pkg::REG_BOX_MIN_Z: box_lo[2] <= wval;
        rbs_pkg::REG_BOX_MAX_X: box_hi[0] <= wval;
        rbs_pkg::REG_BOX_MAX_Y: box_hi[1] <= wval;
        rbs_pkg::REG_BOX_MAX_Z: box_hi[2] <= wval;
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      rbs_pkg::REG_BOX_MIN_X: prdata = DATA_W'(box_lo[0]);
      rbs_pkg::REG_BOX_MIN_Y: prdata = DATA_W'(box_lo[1]);
      rbs_pkg::REG_BOX_MIN_Z: prdata = DATA_W'(box_lo[2]);
      rbs_pkg::REG_BOX_MAX_X: prdata = DATA_W'(box_hi[0]);
      rbs_pkg::REG_BOX_MAX_Y: prdata = DATA_W'(box_hi[1]);
      rbs_pkg::REG_BOX_MAX_Z: prdata = DATA_W'(box_hi[2]);
      default:                prdata = '0;
    endcase
  end

endmodule

>>> design/rbs_prep.sv
// Front stage: per-axis bound selection, distance numerators and divisor magnitudes.
// Depends on rbs_pkg for the sideband struct.
module rbs_prep #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [COORD_WIDTH-1:0] origin [rbs_pkg::AXES],
  input  logic [COORD_WIDTH-1:0] dir    [rbs_pkg::AXES],
  input  logic [COORD_WIDTH-1:0] box_lo [rbs_pkg::AXES],
  input  logic [COORD_WIDTH-1:0] box_hi [rbs_pkg::AXES],
  output logic                   out_valid,
  output rbs_pkg::side_t         side,
  output logic [COORD_WIDTH-1:0] num_near [rbs_pkg::AXES],
  output logic [COORD_WIDTH-1:0] num_far  [rbs_pkg::AXES],
  output logic [COORD_WIDTH-1:0] dmag     [rbs_pkg::AXES]
);

  localparam int W = COORD_WIDTH;

  rbs_pkg::side_t side_next;
  logic [W-1:0]   nn_next [rbs_pkg::AXES];
  logic [W-1:0]   nf_next [rbs_pkg::AXES];
  logic [W-1:0]   dm_next [rbs_pkg::AXES];

  // Pick near/far bounds by direction sign, form |bound - origin|
  always_comb begin
    logic [W-1:0] nb, fb;
    logic         dneg, nlt, flt, outside;
    side_next.miss = 1'b0;
    for (int a = 0; a < rbs_pkg::AXES; a++) begin
      dneg = dir[a][W-1];
      dm_next[a] = dneg ? (~dir[a] + W'(1)) : dir[a];
      nb = dneg ? box_hi[a] : box_lo[a];
      fb = dneg ? box_lo[a] : box_hi[a];
      nlt = $signed(nb) < $signed(origin[a]);
      flt = $signed(fb) < $signed(origin[a]);
      nn_next[a] = nlt ? (origin[a] - nb) : (nb - origin[a]);
      nf_next[a] = flt ? (origin[a] - fb) : (fb - origin[a]);
      side_next.ax[a].dzero    = (dir[a] == '0);
      side_next.ax[a].neg_near = nlt != dneg;
      side_next.ax[a].neg_far  = flt != dneg;
      outside = ($signed(origin[a]) < $signed(box_lo[a])) ||
                ($signed(origin[a]) > $signed(box_hi[a]));
      if (side_next.ax[a].dzero && outside) begin
        side_next.miss = 1'b1;
      end
    end
  end

  // Hold the stage while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side     <= side_next;
      num_near <= nn_next;
      num_far  <= nf_next;
      dmag     <= dm_next;
    end
  end

endmodule

>>> design/rbs_div_lane.sv
// Pipelined restoring divider: floor(num * 2^16 / den), one quotient bit per stage.
// Depends on rbs_pkg for the fraction width.
module rbs_div_lane #(
  parameter int COORD_WIDTH = 32,
  parameter int QW = COORD_WIDTH + 16
) (
  input  logic                   clk,
  input  logic                   adv,
  input  logic [COORD_WIDTH-1:0] num,
  input  logic [COORD_WIDTH-1:0] den,
  output logic [QW-1:0]          quo
);

  localparam int W = COORD_WIDTH;

  // Remainder, shifting numerator/quotient word and divisor after each stage
  logic [W-1:0]  rem [1:QW];
  logic [QW-1:0] nq  [1:QW];
  logic [W-1:0]  dv  [1:QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [W-1:0]  r_in;
    logic [QW-1:0] q_in;
    logic [W-1:0]  d_in;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    // First stage takes the operands, later ones the previous stage
    if (i == 0) begin : g_head
      assign r_in = '0;
      assign q_in = {num, {rbs_pkg::FRAC_BITS{1'b0}}};
      assign d_in = den;
    end else begin : g_link
      assign r_in = rem[i];
      assign q_in = nq[i];
      assign d_in = dv[i];
    end

    // Trial subtract; keep the remainder when it would go negative
    assign trial = {r_in, q_in[QW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1] <= ge ? diff[W-1:0] : trial[W-1:0];
        nq[i+1]  <= {q_in[QW-2:0], ge};
        dv[i+1]  <= d_in;
      end
    end
  end

  assign quo = nq[QW];

endmodule

>>> design/rbs_reduce.sv
// Back end: clamp and sign the quotients, reduce entry/exit over the axes,
// decide hit and saturate into the output register. Depends on rbs_pkg.
module rbs_reduce #(
  parameter int COORD_WIDTH = 32,
  parameter int QW = COORD_WIDTH + 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  rbs_pkg::side_t         side,
  input  logic [QW-1:0]          q_near [rbs_pkg::AXES],
  input  logic [QW-1:0]          q_far  [rbs_pkg::AXES],
  output logic                   out_valid,
  output logic                   hit_found,
  output logic [COORD_WIDTH-2:0] t_enter,
  output logic [COORD_WIDTH-1:0] t_exit
);

  localparam int W  = COORD_WIDTH;
  localparam int MW = (QW > rbs_pkg::TLIM_BITS) ? rbs_pkg::TLIM_BITS : QW;
  localparam int TW = MW + 1;

  logic [MW-1:0] mag_n [rbs_pkg::AXES];
  logic [MW-1:0] mag_f [rbs_pkg::AXES];

  // Saturate the quotient magnitudes
  for (genvar a = 0; a < rbs_pkg::AXES; a++) begin : g_clamp
    if (QW > rbs_pkg::TLIM_BITS) begin : g_sat
      assign mag_n[a] = (|q_near[a][QW-1:rbs_pkg::TLIM_BITS]) ? '1 : q_near[a][MW-1:0];
      assign mag_f[a] = (|q_far[a][QW-1:rbs_pkg::TLIM_BITS])  ? '1 : q_far[a][MW-1:0];
    end else begin : g_pass
      assign mag_n[a] = q_near[a];
      assign mag_f[a] = q_far[a];
    end
  end

  // Stage 1: signed per-axis entry and exit; zero directions enter at 0
  logic                  v1;
  rbs_pkg::side_t        s1;
  logic signed [TW-1:0]  e1 [rbs_pkg::AXES];
  logic signed [TW-1:0]  x1 [rbs_pkg::AXES];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= side;
      for (int a = 0; a < rbs_pkg::AXES; a++) begin
        if (side.ax[a].dzero) begin
          e1[a] <= '0;
        end else if (side.ax[a].neg_near) begin
          e1[a] <= -$signed({1'b0, mag_n[a]});
        end else begin
          e1[a] <= $signed({1'b0, mag_n[a]});
        end
        x1[a] <= side.ax[a].neg_far ? -$signed({1'b0, mag_f[a]}) : $signed({1'b0, mag_f[a]});
      end
    end
  end

  // Stage 2: reduce axes x and y, carry z
  logic                 v2;
  logic                 miss2, xinf01, xinf2;
  logic signed [TW-1:0] e01, x01, e2, x2;

  always_ff @(posedge clk) begin
    if (adv) begin
      miss2  <= s1.miss;
      e01    <= (e1[0] > e1[1]) ? e1[0] : e1[1];
      xinf01 <= s1.ax[0].dzero && s1.ax[1].dzero;
      priority if (s1.ax[0].dzero) begin
        x01 <= x1[1];
      end else if (s1.ax[1].dzero) begin
        x01 <= x1[0];
      end else begin
        x01 <= (x1[0] < x1[1]) ? x1[0] : x1[1];
      end
      e2    <= e1[2];
      x2    <= x1[2];
      xinf2 <= s1.ax[2].dzero;
    end
  end

  // Stage 3: fold in axis z, clamp entry at zero
  logic                 v3;
  logic                 miss3, xinf3;
  logic signed [TW-1:0] ent3, ext3;
  logic signed [TW-1:0] emax;

  assign emax = (e01 > e2) ? e01 : e2;

  always_ff @(posedge clk) begin
    if (adv) begin
      miss3 <= miss2;
      ent3  <= emax[TW-1] ? '0 : emax;
      xinf3 <= xinf01 && xinf2;
      priority if (xinf01) begin
        ext3 <= x2;
      end else if (xinf2) begin
        ext3 <= x01;
      end else begin
        ext3 <= (x01 < x2) ? x01 : x2;
      end
    end
  end

  // Stage 4: hit decision and output saturation
  logic         hit_next;
  logic [W-2:0] ten_sat;
  logic [W-1:0] tex_sat;

  assign hit_next = !miss3 && (xinf3 || (ext3 > ent3));

  if (MW > W - 1) begin : g_ent_sat
    assign ten_sat = (|ent3[TW-2:W-1]) ? '1 : ent3[W-2:0];
  end else begin : g_ent_ext
    assign ten_sat = (W-1)'(ent3[TW-2:0]);
  end

  if (TW > W) begin : g_ext_sat
    logic fits;
    assign fits = (&ext3[TW-1:W-1]) || !(|ext3[TW-1:W-1]);
    assign tex_sat = fits ? ext3[W-1:0] :
                     (ext3[TW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
  end else begin : g_ext_ext
    assign tex_sat = W'(ext3);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_found <= hit_next;
      if (miss3) begin
        t_enter <= '0;
        t_exit  <= '0;
      end else begin
        t_enter <= ten_sat;
        t_exit  <= xinf3 ? {1'b0, {(W-1){1'b1}}} : tex_sat;
      end
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

endmodule

>>> design/ray_box_slab_intersect.sv
// Ray versus axis-aligned box slab test: one ray per cycle, six pipelined dividers.
// One front stage, COORD_WIDTH + 16 divider stages at one quotient bit each, four back stages.
// Throughput: one beat per cycle; a stalled output freezes the whole pipeline.
// Reset: synchronous, clears all valid bits and the six box registers to zero.
module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  // tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (lowest first)
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
  // tdata: t_enter, t_exit (lowest first); tuser: hit_found
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [((2*COORD_WIDTH-1+7)/8)*8-1:0]     m_tdata,
  output logic [0:0]                               m_tuser,
  // configuration port
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [((COORD_WIDTH > 32) ? 6 : 5)-1:0]  paddr,
  input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                                     pready
);

  localparam int W      = COORD_WIDTH;
  localparam int QW     = W + rbs_pkg::FRAC_BITS;
  localparam int ADDR_W = (W > 32) ? 6 : 5;
  localparam int DATA_W = (W > 32) ? 64 : 32;
  localparam int OUT_W  = ((2*W-1+7)/8)*8;

  logic adv;
  logic [W-1:0] box_lo [rbs_pkg::AXES];
  logic [W-1:0] box_hi [rbs_pkg::AXES];
  logic [W-1:0] origin [rbs_pkg::AXES];
  logic [W-1:0] dir    [rbs_pkg::AXES];

  // Whole pipeline moves unless a finished beat waits at the output
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign pready   = 1'b1;

  for (genvar a = 0; a < rbs_pkg::AXES; a++) begin : g_unpack
    assign origin[a] = s_tdata[a*W +: W];
    assign dir[a]    = s_tdata[(rbs_pkg::AXES+a)*W +: W];
  end

  rbs_cfg_regs #(
    .COORD_WIDTH(W),
    .ADDR_W(ADDR_W),
    .DATA_W(DATA_W)
  ) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .box_lo(box_lo),
    .box_hi(box_hi)
  );

  logic           p_valid;
  rbs_pkg::side_t p_side;
  logic [W-1:0]   num_near [rbs_pkg::AXES];
  logic [W-1:0]   num_far  [rbs_pkg::AXES];
  logic [W-1:0]   dmag     [rbs_pkg::AXES];

  rbs_prep #(.COORD_WIDTH(W)) u_prep (
    .clk, .rst, .adv,
    .in_valid(s_tvalid),
    .origin(origin),
    .dir(dir),
    .box_lo(box_lo),
    .box_hi(box_hi),
    .out_valid(p_valid),
    .side(p_side),
    .num_near(num_near),
    .num_far(num_far),
    .dmag(dmag)
  );

  // Six divider lanes: near and far distance for each axis
  logic [QW-1:0] q_near [rbs_pkg::AXES];
  logic [QW-1:0] q_far  [rbs_pkg::AXES];

  for (genvar a = 0; a < rbs_pkg::AXES; a++) begin : g_div
    rbs_div_lane #(.COORD_WIDTH(W), .QW(QW)) u_near (
      .clk, .adv, .num(num_near[a]), .den(dmag[a]), .quo(q_near[a])
    );
    rbs_div_lane #(.COORD_WIDTH(W), .QW(QW)) u_far (
      .clk, .adv, .num(num_far[a]), .den(dmag[a]), .quo(q_far[a])
    );
  end

  // Delay valid and sideband alongside the divider stages
  logic           dvld  [1:QW];
  rbs_pkg::side_t dside [1:QW];

  for (genvar i = 0; i < QW; i++) begin : g_side
    logic           v_in;
    rbs_pkg::side_t s_in;
    if (i == 0) begin : g_head
      assign v_in = p_valid;
      assign s_in = p_side;
    end else begin : g_link
      assign v_in = dvld[i];
      assign s_in = dside[i];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[i+1] <= 1'b0;
      end else if (adv) begin
        dvld[i+1] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dside[i+1] <= s_in;
      end
    end
  end

  logic         hit_found;
  logic [W-2:0] t_enter;
  logic [W-1:0] t_exit;

  rbs_reduce #(.COORD_WIDTH(W), .QW(QW)) u_reduce (
    .clk, .rst, .adv,
    .in_valid(dvld[QW]),
    .side(dside[QW]),
    .q_near(q_near),
    .q_far(q_far),
    .out_valid(m_tvalid),
    .hit_found(hit_found),
    .t_enter(t_enter),
    .t_exit(t_exit)
  );

  assign m_tdata = OUT_W'({t_exit, t_enter});
  assign m_tuser = hit_found;

endmodule

>>> design/rbs_checker.sv
// Port-level checks for ray_box_slab_intersect, attached by bind.
// Depends only on the top level's ports.
module rbs_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                                      clk,
  input logic                                      rst,
  input logic                                      s_tready,
  input logic                                      m_tvalid,
  input logic                                      m_tready,
  input logic [((2*COORD_WIDTH-1+7)/8)*8-1:0]      m_tdata,
  input logic [0:0]                                m_tuser
);

  localparam int W = COORD_WIDTH;

  logic signed [W:0] ent_s;
  logic signed [W:0] ext_s;

  assign ent_s = $signed({2'b00, m_tdata[W-2:0]});
  assign ext_s = $signed({m_tdata[2*W-2], m_tdata[2*W-2:W-1]});

  // No result beat right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

  // A stalled output freezes the input side
  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  // A hit never reports exit before entry
  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> ext_s >= ent_s)
    else $error("hit with exit below entry");

endmodule

bind ray_box_slab_intersect rbs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbs_checker (.*);
